// ----- rtl/core/lmss_pkg.sv -----
// Shared constants, codes and control types of the LED matrix scroll scanner.
package lmss_pkg;

    localparam int STORE_DEPTH = 128;
    localparam int ADDR_W      = $clog2(STORE_DEPTH);
    localparam int RUN_W       = $clog2(STORE_DEPTH + 1);
    localparam int IDX_W       = 7;
    localparam int DATA_W      = 8;
    localparam int LEN_W       = 8;
    localparam int ROW_W       = 3;
    localparam int COL_W       = 3;
    localparam int FUNC_W      = 3;
    localparam int S_TDATA_W   = 32;
    localparam int M_TDATA_W   = 8;
    localparam int MATRIX_COLS = 5;
    localparam int MATRIX_ROWS = 8;

    typedef enum logic [FUNC_W-1:0] {
        FUNC_SCAN   = 3'd0,
        FUNC_SCROLL = 3'd1,
        FUNC_WRITE  = 3'd2,
        FUNC_CLEAR  = 3'd3,
        FUNC_WINDOW = 3'd4
    } func_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN_RD,
        ST_CLEAR
    } state_t;

    typedef struct packed {
        logic scan_issue;
        logic scroll;
        logic write;
        logic clear_start;
        logic clear_step;
        logic set_window;
        logic out_load;
    } cmd_t;

    typedef struct packed {
        logic clear_ok;
        logic clear_last;
        logic out_free;
    } status_t;

endpackage

// ----- rtl/core/lmss_ram.sv -----
// Generic single-port-write, single-port-read RAM with registered read data.
module lmss_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 128
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ----- rtl/core/lmss_ctrl.sv -----
// Controller state machine that sequences scan reads, clear runs and result loads.
module lmss_ctrl (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          s_tvalid,
    input  logic [lmss_pkg::FUNC_W-1:0]   s_tuser,
    output logic                          s_tready,
    input  lmss_pkg::status_t             status,
    output lmss_pkg::cmd_t                cmd
);

    lmss_pkg::state_t state_reg;
    lmss_pkg::state_t state_next;
    lmss_pkg::func_t  func;

    assign func = lmss_pkg::func_t'(s_tuser);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= lmss_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        s_tready   = 1'b0;
        case (state_reg)
            lmss_pkg::ST_IDLE:
            begin
                s_tready = 1'b1;
                if (s_tvalid)
                begin
                    case (func)
                        lmss_pkg::FUNC_SCAN:
                        begin
                            cmd.scan_issue = 1'b1;
                            state_next     = lmss_pkg::ST_SCAN_RD;
                        end
                        lmss_pkg::FUNC_SCROLL: cmd.scroll = 1'b1;
                        lmss_pkg::FUNC_WRITE:  cmd.write  = 1'b1;
                        lmss_pkg::FUNC_CLEAR:
                        begin
                            cmd.clear_start = 1'b1;
                            if (status.clear_ok)
                            begin
                                state_next = lmss_pkg::ST_CLEAR;
                            end
                        end
                        lmss_pkg::FUNC_WINDOW: cmd.set_window = 1'b1;
                        default: ;
                    endcase
                end
            end
            lmss_pkg::ST_SCAN_RD:
            begin
                if (status.out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = lmss_pkg::ST_IDLE;
                end
            end
            lmss_pkg::ST_CLEAR:
            begin
                cmd.clear_step = 1'b1;
                if (status.clear_last)
                begin
                    state_next = lmss_pkg::ST_IDLE;
                end
            end
            default: state_next = lmss_pkg::ST_IDLE;
        endcase
    end

endmodule

// ----- rtl/core/lmss_dp.sv -----
// Datapath with the column store, window and scan registers, and the result register.
module lmss_dp (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic [lmss_pkg::S_TDATA_W-1:0]   s_tdata,
    output logic                             m_tvalid,
    input  logic                             m_tready,
    output logic [lmss_pkg::M_TDATA_W-1:0]   m_tdata,
    input  lmss_pkg::cmd_t                   cmd,
    output lmss_pkg::status_t                status
);

    logic [lmss_pkg::IDX_W-1:0]  idx;
    logic [lmss_pkg::DATA_W-1:0] col_data;
    logic [lmss_pkg::LEN_W-1:0]  run_len;
    logic [lmss_pkg::IDX_W-1:0]  win_last;

    logic [lmss_pkg::IDX_W-1:0]  ws_reg;
    logic [lmss_pkg::IDX_W-1:0]  ws_next;
    logic [lmss_pkg::IDX_W-1:0]  we_reg;
    logic [lmss_pkg::ROW_W-1:0]  row_reg;
    logic [lmss_pkg::COL_W-1:0]  col_reg;
    logic [lmss_pkg::ROW_W-1:0]  pend_row_reg;
    logic [lmss_pkg::COL_W-1:0]  pend_col_reg;
    logic                        pend_vld_reg;

    logic [lmss_pkg::STORE_DEPTH-1:0] vld_reg;
    logic [lmss_pkg::ADDR_W-1:0]      clr_addr_reg;
    logic [lmss_pkg::RUN_W-1:0]       clr_cnt_reg;

    logic                          out_valid_reg;
    logic [lmss_pkg::ROW_W-1:0]    out_row_reg;
    logic [lmss_pkg::COL_W-1:0]    out_col_reg;
    logic                          out_led_reg;

    logic [lmss_pkg::IDX_W:0]      scan_sum;
    logic [lmss_pkg::ADDR_W-1:0]   rd_addr;
    logic [lmss_pkg::IDX_W:0]      scroll_sum;
    logic                          wr_in_range;
    logic                          wr_en;
    logic [lmss_pkg::ADDR_W-1:0]   wr_addr;
    logic [lmss_pkg::DATA_W-1:0]   rd_data;

    assign idx      = s_tdata[6:0];
    assign col_data = s_tdata[14:7];
    assign run_len  = s_tdata[22:15];
    assign win_last = s_tdata[29:23];

    assign scan_sum    = {1'b0, ws_reg} + (lmss_pkg::IDX_W + 1)'(col_reg);
    assign rd_addr     = lmss_pkg::ADDR_W'(scan_sum);
    assign wr_in_range = int'(idx) <= lmss_pkg::STORE_DEPTH - 1;
    assign wr_en       = cmd.write && wr_in_range;
    assign wr_addr     = lmss_pkg::ADDR_W'(idx);

    assign status.clear_ok   = wr_in_range && (run_len != '0)
                               && (int'(run_len) <= lmss_pkg::STORE_DEPTH);
    assign status.clear_last = (clr_cnt_reg == lmss_pkg::RUN_W'(1));
    assign status.out_free   = !out_valid_reg || m_tready;

    lmss_ram #(
        .WIDTH (lmss_pkg::DATA_W),
        .DEPTH (lmss_pkg::STORE_DEPTH)
    ) u_store (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (col_data),
        .rd_en   (cmd.scan_issue),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    always_comb
    begin
        scroll_sum = {1'b0, ws_reg} + (lmss_pkg::IDX_W + 1)'(1);
        ws_next    = scroll_sum[lmss_pkg::IDX_W-1:0];
        if ((int'(scroll_sum) > lmss_pkg::STORE_DEPTH - 1) || (scroll_sum > {1'b0, we_reg}))
        begin
            ws_next = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ws_reg        <= '0;
            we_reg        <= '0;
            row_reg       <= '0;
            col_reg       <= '0;
            vld_reg       <= '0;
            clr_cnt_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.scroll)
            begin
                ws_reg <= ws_next;
            end
            if (cmd.set_window)
            begin
                ws_reg <= idx;
                we_reg <= win_last;
            end
            if (cmd.scan_issue)
            begin
                if (col_reg == lmss_pkg::COL_W'(lmss_pkg::MATRIX_COLS - 1))
                begin
                    col_reg <= '0;
                    if (row_reg == lmss_pkg::ROW_W'(lmss_pkg::MATRIX_ROWS - 1))
                    begin
                        row_reg <= '0;
                    end
                    else
                    begin
                        row_reg <= row_reg + lmss_pkg::ROW_W'(1);
                    end
                end
                else
                begin
                    col_reg <= col_reg + lmss_pkg::COL_W'(1);
                end
            end
            if (wr_en)
            begin
                vld_reg[wr_addr] <= 1'b1;
            end
            if (cmd.clear_start && status.clear_ok)
            begin
                clr_cnt_reg <= lmss_pkg::RUN_W'(run_len);
            end
            if (cmd.clear_step)
            begin
                vld_reg[clr_addr_reg] <= 1'b0;
                clr_cnt_reg           <= clr_cnt_reg - lmss_pkg::RUN_W'(1);
            end
            if (cmd.out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.scan_issue)
        begin
            pend_row_reg <= row_reg;
            pend_col_reg <= col_reg;
            pend_vld_reg <= vld_reg[rd_addr];
        end
        if (cmd.clear_start)
        begin
            clr_addr_reg <= wr_addr;
        end
        else if (cmd.clear_step)
        begin
            clr_addr_reg <= clr_addr_reg + lmss_pkg::ADDR_W'(1);
        end
        if (cmd.out_load)
        begin
            out_row_reg <= pend_row_reg;
            out_col_reg <= pend_col_reg;
            out_led_reg <= pend_vld_reg && rd_data[pend_row_reg];
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {1'b0, out_led_reg, out_col_reg, out_row_reg};

endmodule

// ----- rtl/core/led_matrix_scroll_scanner_top.sv -----
// Top level of the LED matrix scroll scanner: controller, datapath and checks.
//
// Commands arrive on the slave stream: tuser carries the function code and tdata
// the index, column byte, run length and window end. Only a scan tick gives a
// result on the master stream: the row, the column and whether that LED is lit.
// A scan tick reads one column byte from the store RAM into a registered read
// port; the controller then sits in its scan-read state, loads the result
// register and only then takes the next command, so one scan ends before the
// next begins. Scroll, write and set-window commands are taken in idle. A clear
// run clears a single valid-bit entry per cycle, one entry per cleared byte.
// The result register frees the input side: commands that give no result are
// taken while a result waits. A scan waits in its read state while the
// receiver stalls and the previous result is still held.
// Reset clears the window, the scan position and all store valid bits, so the
// store reads as zero right away; no clearing pass is needed.
module led_matrix_scroll_scanner_top (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    // index [6:0], column_data [14:7], run_length [22:15], window_last [29:23]
    input  logic [lmss_pkg::S_TDATA_W-1:0]   s_tdata,
    // func [2:0]
    input  logic [lmss_pkg::FUNC_W-1:0]      s_tuser,
    output logic                             m_tvalid,
    input  logic                             m_tready,
    // row_select [2:0], column_select [5:3], led_on [6]
    output logic [lmss_pkg::M_TDATA_W-1:0]   m_tdata
);

    lmss_pkg::cmd_t    cmd;
    lmss_pkg::status_t status;

    lmss_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tuser  (s_tuser),
        .s_tready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    lmss_dp u_dp (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .cmd      (cmd),
        .status   (status)
    );

    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tdata[5:3] <= 3'd4))
        else $error("column select out of range");

    assert property (@(posedge clk) disable iff (!rst_n)
        s_tready |-> !cmd.clear_step)
        else $error("clear step while taking commands");

    assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready && (s_tuser == lmss_pkg::FUNC_SCAN)) |=> !s_tready)
        else $error("command taken during scan read");

endmodule
